// ----- src/assert_macros.svh -----
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define NO_ASSERTIONS to drop them.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- src/lvc_pkg.sv -----
// -----------------------------------------------------------------------------
// lvc_pkg
// Types, widths and constant tables of the clipped 3x3 local variance filter.
// -----------------------------------------------------------------------------
package lvc_pkg;

  localparam int N_LANES  = 9;
  localparam int PIX_W    = 8;
  localparam int SQ_W     = 16;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int CNT_W    = 4;
  localparam int SUM_W    = 12;  // up to 9 * 255
  localparam int SQS_W    = 20;  // up to 9 * 255^2
  localparam int PROD_W   = 24;  // n*q and s*s
  localparam int NUM_W    = 21;  // n*q - s*s never exceeds 81 * 255^2 / 4
  localparam int VAR_W    = 22;
  localparam int DEN_W    = 7;   // n*n up to 81
  localparam int RECIP_W  = 32;
  localparam int RECIP_SH = 23;  // 31-bit reciprocal scale minus 8 fraction bits
  localparam int FRAC_W   = 8;
  localparam int REM_W    = NUM_W + FRAC_W + 1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

  typedef struct packed {
    logic [COORD_W-1:0] center_col;
    logic [COORD_W-1:0] center_row;
    logic [PIX_W-1:0]   pix_nw;
    logic [PIX_W-1:0]   pix_n;
    logic [PIX_W-1:0]   pix_ne;
    logic [PIX_W-1:0]   pix_w;
    logic [PIX_W-1:0]   pix_c;
    logic [PIX_W-1:0]   pix_e;
    logic [PIX_W-1:0]   pix_sw;
    logic [PIX_W-1:0]   pix_s;
    logic [PIX_W-1:0]   pix_se;
  } in_t;

  typedef struct packed {
    logic [VAR_W-1:0] variance_q8;
    logic [CNT_W-1:0] kept_count;
  } out_t;

  // One lane's finding: pixel and its square, zeroed when outside the image.
  typedef struct packed {
    logic             keep;
    logic [PIX_W-1:0] pix;
    logic [SQ_W-1:0]  sq;
  } lane_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] s;
    logic [SQS_W-1:0] q;
  } stats_t;

  // floor(2^31 / n^2); the estimate is at most one below the true quotient.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 32'd2147483648;
      4'd2:    r = 32'd536870912;
      4'd3:    r = 32'd238609294;
      4'd4:    r = 32'd134217728;
      4'd5:    r = 32'd85899345;
      4'd6:    r = 32'd59652323;
      4'd7:    r = 32'd43826196;
      4'd8:    r = 32'd33554432;
      4'd9:    r = 32'd26512143;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DEN_W-1:0] den(input logic [CNT_W-1:0] n);
    logic [DEN_W-1:0] d;
    case (n)
      4'd1:    d = 7'd1;
      4'd2:    d = 7'd4;
      4'd3:    d = 7'd9;
      4'd4:    d = 7'd16;
      4'd5:    d = 7'd25;
      4'd6:    d = 7'd36;
      4'd7:    d = 7'd49;
      4'd8:    d = 7'd64;
      4'd9:    d = 7'd81;
      default: d = 7'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- src/lvc_lane.sv -----
// -----------------------------------------------------------------------------
// lvc_lane
// One window position: bounds test, masked pixel and its square, registered.
// -----------------------------------------------------------------------------
module lvc_lane #(
  parameter int COL_OFS = 0,  // 0, 1, 2 for column offset -1, 0, +1
  parameter int ROW_OFS = 0   // 0, 1, 2 for row offset -1, 0, +1
) (
  input  logic                       clk,
  input  logic [lvc_pkg::COORD_W-1:0] col,
  input  logic [lvc_pkg::COORD_W-1:0] row,
  input  logic [lvc_pkg::DIM_W-1:0]   lim_w,
  input  logic [lvc_pkg::DIM_W-1:0]   lim_h,
  input  logic [lvc_pkg::PIX_W-1:0]   pix,
  output lvc_pkg::lane_t              lane_r
);

  logic [lvc_pkg::DIM_W-1:0] pos_c;
  logic [lvc_pkg::DIM_W-1:0] pos_r;
  logic                      col_ok;
  logic                      row_ok;
  lvc_pkg::lane_t            lane_nxt;

  assign pos_c = {1'b0, col} + lvc_pkg::DIM_W'(COL_OFS) - lvc_pkg::DIM_W'(1);
  assign pos_r = {1'b0, row} + lvc_pkg::DIM_W'(ROW_OFS) - lvc_pkg::DIM_W'(1);

  // Offset -1 at coordinate 0 wraps; drop it as left of / above the image.
  assign col_ok = !(COL_OFS == 0 && col == '0) && (pos_c < lim_w);
  assign row_ok = !(ROW_OFS == 0 && row == '0) && (pos_r < lim_h);

  always_comb begin
    lane_nxt.keep = col_ok && row_ok;
    lane_nxt.pix  = lane_nxt.keep ? pix : '0;
    lane_nxt.sq   = lvc_pkg::SQ_W'(lane_nxt.pix * lane_nxt.pix);
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

endmodule

// ----- src/lvc_merge.sv -----
// -----------------------------------------------------------------------------
// lvc_merge
// Combine the lane results into count, sum and sum of squares.
// -----------------------------------------------------------------------------
module lvc_merge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_in,
  input  lvc_pkg::lane_t lanes [lvc_pkg::N_LANES],
  output logic           valid_r,
  output lvc_pkg::stats_t stats_r
);

  lvc_pkg::stats_t stats_nxt;

  always_comb begin
    stats_nxt = '0;
    for (int k = 0; k < lvc_pkg::N_LANES; k++) begin
      stats_nxt.n = stats_nxt.n + lvc_pkg::CNT_W'(lanes[k].keep);
      stats_nxt.s = stats_nxt.s + lvc_pkg::SUM_W'(lanes[k].pix);
      stats_nxt.q = stats_nxt.q + lvc_pkg::SQS_W'(lanes[k].sq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    stats_r <= stats_nxt;
  end

endmodule

// ----- src/lvc_div.sv -----
// -----------------------------------------------------------------------------
// lvc_div
// Variance from count, sum and sum of squares: (n*Q - S^2) * 256 / n^2,
// by reciprocal multiply and a one-step correction, four stages.
// -----------------------------------------------------------------------------
module lvc_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_in,
  input  lvc_pkg::stats_t stats,
  output logic            valid_r,
  output lvc_pkg::out_t   res_r
);

  // stage A: products
  logic                       va_r;
  logic [lvc_pkg::CNT_W-1:0]  na_r;
  logic [lvc_pkg::PROD_W-1:0] nq_r, nq_nxt;
  logic [lvc_pkg::PROD_W-1:0] ss_r, ss_nxt;
  // stage B: numerator
  logic                       vb_r;
  logic [lvc_pkg::CNT_W-1:0]  nb_r;
  logic [lvc_pkg::NUM_W-1:0]  num_r, num_nxt;
  // stage C: quotient estimate
  logic                       vc_r;
  logic [lvc_pkg::CNT_W-1:0]  nc_r;
  logic [lvc_pkg::NUM_W-1:0]  numc_r;
  logic [lvc_pkg::VAR_W-1:0]  qe_r, qe_nxt;
  logic [lvc_pkg::NUM_W+lvc_pkg::RECIP_W-1:0] prod;
  // stage D: correction
  logic [lvc_pkg::DEN_W-1:0]  d;
  logic [lvc_pkg::REM_W-1:0]  rem;
  lvc_pkg::out_t              res_nxt;

  assign nq_nxt  = lvc_pkg::PROD_W'(stats.n * stats.q);
  assign ss_nxt  = lvc_pkg::PROD_W'(stats.s * stats.s);
  assign num_nxt = lvc_pkg::NUM_W'(nq_r - ss_r);
  assign prod    = num_r * lvc_pkg::recip(nb_r);
  assign qe_nxt  = lvc_pkg::VAR_W'(prod >> lvc_pkg::RECIP_SH);

  always_comb begin
    d   = lvc_pkg::den(nc_r);
    rem = lvc_pkg::REM_W'({numc_r, lvc_pkg::FRAC_W'(0)}) - lvc_pkg::REM_W'(qe_r * d);
    res_nxt.kept_count = nc_r;
    if (nc_r == '0) begin
      res_nxt.variance_q8 = '0;
    end else if (rem >= lvc_pkg::REM_W'(d)) begin
      res_nxt.variance_q8 = qe_r + lvc_pkg::VAR_W'(1);
    end else begin
      res_nxt.variance_q8 = qe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      vc_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      va_r    <= valid_in;
      vb_r    <= va_r;
      vc_r    <= vb_r;
      valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    na_r   <= stats.n;
    nq_r   <= nq_nxt;
    ss_r   <= ss_nxt;
    nb_r   <= na_r;
    num_r  <= num_nxt;
    nc_r   <= nb_r;
    numc_r <= num_r;
    qe_r   <= qe_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ----- src/local_variance_3x3_clipped.sv -----
// -----------------------------------------------------------------------------
// local_variance_3x3_clipped
// Population variance (Q8, truncated) of the in-image pixels of a 3x3 window.
// -----------------------------------------------------------------------------
// Usage: present a window on in_data and raise start; it transfers at the
// edge where start is high and busy is low. busy stays low, so a window can
// transfer on every clock: throughput is one window per cycle. Each result
// appears on out_data for exactly one cycle with out_valid high, registered
// through one lane stage, one merge stage and four divide stages, in input
// order. The receiver cannot stall the block: it must take every result in
// the cycle it is shown. Write image_width (index 0) and image_height
// (index 1) only while no window is in flight; values above MAX_DIM act as
// MAX_DIM and zero keeps no pixel.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module local_variance_3x3_clipped #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  lvc_pkg::in_t                  in_data,
  // result channel
  output logic                          out_valid,
  output lvc_pkg::out_t                 out_data,
  // configuration
  input  logic                          cfg_we,
  input  logic [lvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lvc_pkg::DIM_W-1:0]     cfg_wdata
);

  logic [lvc_pkg::DIM_W-1:0] image_width_r, image_width_nxt;
  logic [lvc_pkg::DIM_W-1:0] image_height_r, image_height_nxt;
  logic [lvc_pkg::DIM_W-1:0] lim_w;
  logic [lvc_pkg::DIM_W-1:0] lim_h;
  logic                      accept;
  logic                      lane_valid_r;
  logic                      merge_valid;
  lvc_pkg::stats_t           stats;
  lvc_pkg::lane_t            lanes [lvc_pkg::N_LANES];
  logic [lvc_pkg::PIX_W-1:0] pix [lvc_pkg::N_LANES];

  // Every transfer is taken; the pipeline never backs up.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Register writes: decode the index, ignore nothing else.
  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lvc_pkg::CFG_IMAGE_WIDTH:  image_width_nxt  = cfg_wdata;
        lvc_pkg::CFG_IMAGE_HEIGHT: image_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= lvc_pkg::DIM_RESET;
      image_height_r <= lvc_pkg::DIM_RESET;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
    end
  end

  // Saturate the image size at MAX_DIM.
  assign lim_w = (32'(image_width_r) > 32'(MAX_DIM))  ? lvc_pkg::DIM_W'(MAX_DIM)
                                                       : image_width_r;
  assign lim_h = (32'(image_height_r) > 32'(MAX_DIM)) ? lvc_pkg::DIM_W'(MAX_DIM)
                                                       : image_height_r;

  // Lane order is raster order: west to east, then north to south.
  assign pix[0] = in_data.pix_nw;
  assign pix[1] = in_data.pix_n;
  assign pix[2] = in_data.pix_ne;
  assign pix[3] = in_data.pix_w;
  assign pix[4] = in_data.pix_c;
  assign pix[5] = in_data.pix_e;
  assign pix[6] = in_data.pix_sw;
  assign pix[7] = in_data.pix_s;
  assign pix[8] = in_data.pix_se;

  for (genvar k = 0; k < lvc_pkg::N_LANES; k++) begin : g_lane
    lvc_lane #(
      .COL_OFS (k % 3),
      .ROW_OFS (k / 3)
    ) u_lane (
      .clk    (clk),
      .col    (in_data.center_col),
      .row    (in_data.center_row),
      .lim_w  (lim_w),
      .lim_h  (lim_h),
      .pix    (pix[k]),
      .lane_r (lanes[k])
    );
  end

  // Lane stage valid: advance with each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_valid_r <= 1'b0;
    end else begin
      lane_valid_r <= accept;
    end
  end

  lvc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (lane_valid_r),
    .lanes    (lanes),
    .valid_r  (merge_valid),
    .stats_r  (stats)
  );

  lvc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (merge_valid),
    .stats    (stats),
    .valid_r  (out_valid),
    .res_r    (out_data)
  );

  // Every transfer yields its result after the fixed latency.
  `ASSERT_CLK(a_latency, clk, rst_n, accept |-> ##6 out_valid)
  // No result without an earlier window.
  `ASSERT_CLK(a_no_spurious, clk, rst_n, out_valid |-> $past(accept, 6))
  // At most nine pixels are kept.
  `ASSERT_NEVER(a_count_range, clk, rst_n, out_valid && (out_data.kept_count > 4'd9))
  // Empty or single-pixel windows have no spread.
  `ASSERT_NEVER(a_trivial_var, clk, rst_n,
                out_valid && (out_data.kept_count < 4'd2) && (out_data.variance_q8 != '0))
  // Variance of 8-bit data never exceeds (255/2)^2 in Q8.
  `ASSERT_NEVER(a_var_range, clk, rst_n, out_valid && (out_data.variance_q8 > 22'd4161600))

endmodule

// ----- tb/local_variance_3x3_clipped_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// local_variance_3x3_clipped_tb
// Self-checking bench for the clipped 3x3 local variance filter. Windows are
// queued by the stimulus process, sent by a clocked driver that idles at
// random, and each result is checked against a variance predictor that keeps
// its own copy of the image size registers.
// -----------------------------------------------------------------------------
module local_variance_3x3_clipped_tb;

  localparam int MAX_DIM       = 4096;
  localparam int LATENCY       = 6;
  localparam int DRAIN_CYCLES  = LATENCY + 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 155;  // per size setting, ten settings

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  lvc_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  lvc_pkg::out_t                 out_data;
  logic                          cfg_we = 1'b0;
  logic [lvc_pkg::CFG_IDX_W-1:0] cfg_index = lvc_pkg::CFG_IMAGE_WIDTH;
  logic [lvc_pkg::DIM_W-1:0]     cfg_wdata = '0;

  // Predictor copy of the size registers; follows every write the block sees.
  logic [lvc_pkg::DIM_W-1:0]     cur_width = lvc_pkg::DIM_RESET;
  logic [lvc_pkg::DIM_W-1:0]     cur_height = lvc_pkg::DIM_RESET;

  lvc_pkg::in_t  windows_to_send[$];
  lvc_pkg::out_t variance_due[$];
  int            sender_idle_pct = 0;
  int            mismatch_count = 0;
  int            stall_cycles = 0;

  local_variance_3x3_clipped #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Size registers above the largest image act as the largest image.
  function automatic int clamp_dim(input logic [lvc_pkg::DIM_W-1:0] dim);
    return (int'(dim) > MAX_DIM) ? MAX_DIM : int'(dim);
  endfunction

  // Append a window at the tail of the send queue.
  function automatic void queue_window(input lvc_pkg::in_t win);
    windows_to_send.insert(windows_to_send.size(), win);
  endfunction

  // Variance of the in-image pixels of one window: (n*Q - S*S) * 256 / n^2,
  // truncated. Positions are scanned west to east, north to south.
  function automatic lvc_pkg::out_t predict_variance(input lvc_pkg::in_t win,
                                                     input logic [lvc_pkg::DIM_W-1:0] width,
                                                     input logic [lvc_pkg::DIM_W-1:0] height);
    logic [lvc_pkg::PIX_W-1:0] pix [9];
    int                        lim_c;
    int                        lim_r;
    int                        c;
    int                        r;
    longint                    n;
    longint                    s;
    longint                    q;
    longint                    var_q8;
    lvc_pkg::out_t             res;
    pix = '{win.pix_nw, win.pix_n, win.pix_ne, win.pix_w, win.pix_c, win.pix_e,
            win.pix_sw, win.pix_s, win.pix_se};
    lim_c = clamp_dim(width);
    lim_r = clamp_dim(height);
    n = 0;
    s = 0;
    q = 0;
    for (int k = 0; k < 9; k++) begin
      c = int'(win.center_col) + (k % 3) - 1;
      r = int'(win.center_row) + (k / 3) - 1;
      if (c >= 0 && c < lim_c && r >= 0 && r < lim_r) begin
        n += 1;
        s += longint'(pix[k]);
        q += longint'(pix[k]) * longint'(pix[k]);
      end
    end
    var_q8 = (n == 0) ? 0 : ((n * q - s * s) << lvc_pkg::FRAC_W) / (n * n);
    res.variance_q8 = var_q8[lvc_pkg::VAR_W-1:0];
    res.kept_count  = n[lvc_pkg::CNT_W-1:0];
    return res;
  endfunction

  // Coordinates: often at or around the image borders, else inside or just past the image, or anywhere.
  function automatic logic [lvc_pkg::COORD_W-1:0] random_coord(input int dim);
    int v;
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      case ($urandom_range(5))
        0:       v = 0;
        1:       v = 1;
        2:       v = dim - 2;
        3:       v = dim - 1;
        4:       v = dim;
        default: v = dim + 1;
      endcase
    end else if (pick < 7) begin
      v = $urandom_range(dim + 1);
    end else begin
      v = $urandom_range(4095);
    end
    return v[lvc_pkg::COORD_W-1:0];
  endfunction

  // Pixels, nw first: noise, flat, two extremes, or small spread around a base.
  function automatic logic [9*lvc_pkg::PIX_W-1:0] random_pixels();
    logic [9*lvc_pkg::PIX_W-1:0] p;
    logic [lvc_pkg::PIX_W-1:0]   base;
    int                          mode;
    mode = $urandom_range(3);
    base = lvc_pkg::PIX_W'($urandom_range(255));
    for (int k = 0; k < 9; k++) begin
      case (mode)
        0:       p[k*lvc_pkg::PIX_W +: lvc_pkg::PIX_W] = lvc_pkg::PIX_W'($urandom_range(255));
        1:       p[k*lvc_pkg::PIX_W +: lvc_pkg::PIX_W] = base;
        2:       p[k*lvc_pkg::PIX_W +: lvc_pkg::PIX_W] = $urandom_range(1) ? 8'hFF : 8'h00;
        default: p[k*lvc_pkg::PIX_W +: lvc_pkg::PIX_W] =
                   base ^ lvc_pkg::PIX_W'($urandom_range(3));
      endcase
    end
    return p;
  endfunction

  // Driver: hold a window until it transfers, then advance to the next one
  // or idle at random. The prediction is taken at the transfer edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        variance_due.insert(variance_due.size(),
                            predict_variance(in_data, cur_width, cur_height));
        void'(windows_to_send.pop_front());
      end
      if (windows_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start   <= 1'b1;
        in_data <= windows_to_send[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: track register writes and check every result strobe against the
  // oldest prediction, field by field.
  always @(posedge clk) begin
    lvc_pkg::out_t exp_res;
    if (!rst_n) begin
      cur_width  <= lvc_pkg::DIM_RESET;
      cur_height <= lvc_pkg::DIM_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lvc_pkg::CFG_IMAGE_WIDTH) begin
          cur_width <= cfg_wdata;
        end else if (cfg_index == lvc_pkg::CFG_IMAGE_HEIGHT) begin
          cur_height <= cfg_wdata;
        end
      end
      if (out_valid) begin
        if (variance_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual variance %0d count %0d",
                   $time, out_data.variance_q8, out_data.kept_count);
        end else begin
          exp_res = variance_due.pop_front();
          if (out_data.variance_q8 !== exp_res.variance_q8) begin
            mismatch_count++;
            $display("%0t: variance_q8 mismatch, expected %0d, actual %0d",
                     $time, exp_res.variance_q8, out_data.variance_q8);
          end
          if (out_data.kept_count !== exp_res.kept_count) begin
            mismatch_count++;
            $display("%0t: kept_count mismatch, expected %0d, actual %0d",
                     $time, exp_res.kept_count, out_data.kept_count);
          end
        end
      end
    end
  end

  // Watchdog: drop the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("local_variance_3x3_clipped verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Wait for every queued window to transfer and every result to arrive,
  // then let the pipeline drain.
  task automatic wait_idle();
    while (windows_to_send.size() != 0 || variance_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both size registers while idle, then queue a burst of random windows
  // aimed at the borders of that image size.
  task automatic run_size_setting(input logic [lvc_pkg::DIM_W-1:0] width,
                                  input logic [lvc_pkg::DIM_W-1:0] height,
                                  input int idle_pct);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= lvc_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_index <= lvc_pkg::CFG_IMAGE_HEIGHT;
    cfg_wdata <= height;
    @(posedge clk);
    cfg_we <= 1'b0;
    sender_idle_pct = idle_pct;
    repeat (RANDOM_ITEMS) begin
      queue_window({random_coord(clamp_dim(width)),
                    random_coord(clamp_dim(height)), random_pixels()});
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed windows at the reset size (4096 x 4096): corners, edges,
    // flat windows, the widest spread and a lone bright pixel.
    sender_idle_pct = 0;
    queue_window({12'd0,    12'd0,    {9{8'hFF}}});
    queue_window({12'd0,    12'd0,    72'h00FF00_FF00FF_00FF00});
    queue_window({12'd4095, 12'd4095, 72'h102030_405060_708090});
    queue_window({12'd0,    12'd4095, 72'hFF00FF_00FF00_FF00FF});
    queue_window({12'd4095, 12'd0,    72'hFF00FF_00FF00_FF00FF});
    queue_window({12'd100,  12'd100,  {9{8'h00}}});
    queue_window({12'd100,  12'd100,  {9{8'hFF}}});
    queue_window({12'd2000, 12'd2000, 72'hFF00FF_00FF00_FF00FF});
    queue_window({12'd2000, 12'd2000, 72'h00FF00_FF00FF_00FF00});
    queue_window({12'd1,    12'd1,    72'h000102_030405_060708});
    queue_window({12'd4094, 12'd4094, 72'hFF00FF_00FF00_FF00FF});
    queue_window({12'd0,    12'd2000, 72'h0A1B2C_3D4E5F_60718F});
    queue_window({12'd2000, 12'd0,    72'h0A1B2C_3D4E5F_60718F});
    queue_window({12'd4095, 12'd2000, 72'hAA5512_34FEDC_BA9876});
    queue_window({12'd2000, 12'd4095, 72'hAA5512_34FEDC_BA9876});
    queue_window({12'd300,  12'd300,  72'h000000_00FF00_000000});
    queue_window({12'd1,    12'd4094, 72'hFFFFFF_FFFFFF_FFFF00});
    queue_window({12'd4094, 12'd1,    72'h800000_000000_000001});
    queue_window({12'd3000, 12'd5,    72'h7F80FE_01FF00_55AA33});

    // Random bursts over a range of image sizes: saturated, minimal, empty,
    // one-line and odd shapes. Sender idles lightly, then heavily, then never.
    run_size_setting(13'd8191, 13'd8191, 9);
    run_size_setting(13'd1,    13'd1,    9);
    run_size_setting(13'd0,    13'd4096, 9);
    run_size_setting(13'd3,    13'd2,    9);
    run_size_setting(13'd4097, 13'd0,    77);
    run_size_setting(13'd16,   13'd9,    77);
    run_size_setting(lvc_pkg::DIM_W'($urandom_range(1, 64)),
                     lvc_pkg::DIM_W'($urandom_range(1, 64)), 77);
    run_size_setting(13'd4096, 13'd4096, 0);
    run_size_setting(13'd2,    13'd4095, 0);
    run_size_setting(lvc_pkg::DIM_W'($urandom_range(8191)),
                     lvc_pkg::DIM_W'($urandom_range(8191)), 0);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("local_variance_3x3_clipped verification clean");
    end else begin
      $display("local_variance_3x3_clipped verification failed");
    end
    $finish;
  end

endmodule
